FILE: hdl/bej_pkg.sv
// shared types and constants for the bej tuple stream decoder
package bej_pkg;

    localparam int MAX_NESTING = 32;
    localparam int OFFSET_BITS = 32;
    localparam int NEST_W      = $clog2(MAX_NESTING);
    localparam int LEVEL_W     = 6;

    localparam logic [LEVEL_W-1:0]     NEST_CAP   = LEVEL_W'(MAX_NESTING < 37 ? MAX_NESTING : 37);
    localparam logic [LEVEL_W-1:0]     NEST_FULL  = LEVEL_W'(MAX_NESTING);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX    = '1;
    localparam logic [31:0]            MAGIC_A    = 32'hF0F1F000;
    localparam logic [31:0]            MAGIC_B    = 32'hF1F0F000;
    localparam logic [7:0]             NO_HDR_MAX = 8'd8;
    localparam logic [7:0]             NN_MAX     = 8'd8;
    localparam logic [2:0]             HDR_PROBE  = 3'd4;
    localparam logic [63:0]            HDR_REST   = 64'd3;

    localparam logic [2:0] EV_SET_BEGIN = 3'd0;
    localparam logic [2:0] EV_SET_END   = 3'd1;
    localparam logic [2:0] EV_KEY       = 3'd2;
    localparam logic [2:0] EV_STR_BYTE  = 3'd3;
    localparam logic [2:0] EV_STR_END   = 3'd4;
    localparam logic [2:0] EV_INT       = 3'd5;
    localparam logic [2:0] EV_SKIPPED   = 3'd6;
    localparam logic [2:0] EV_FINISHED  = 3'd7;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_TRUNC = 3'd1;
    localparam logic [2:0] ST_PARSE = 3'd2;
    localparam logic [2:0] ST_DEPTH = 3'd3;
    localparam logic [2:0] ST_UNSUP = 3'd4;

    localparam logic [3:0] FMT_SET     = 4'h0;
    localparam logic [3:0] FMT_INTEGER = 4'h3;
    localparam logic [3:0] FMT_STRING  = 4'h5;

    localparam logic CFG_STRICT = 1'b0;
    localparam logic CFG_DEPTH  = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR, PH_HSKIP, PH_SEQ_N, PH_SEQ_B, PH_FMT, PH_LEN_N, PH_LEN_B,
        PH_CNT_N, PH_CNT_B, PH_STR, PH_INT, PH_SKIP, PH_SLACK, PH_DONE
    } phase_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_DISPATCH, OP_HDR_DECIDE, OP_REPLAY, OP_CONSUME,
        OP_FIELD_DONE, OP_VALUE_START, OP_VALUE_FMT, OP_BEGIN_SKIP, OP_SET_OPEN,
        OP_INT_EMIT, OP_ADVANCE, OP_CLOSE_TOP, OP_FINISH, OP_LAST_CHECK,
        OP_CLEAR, OP_FLUSH
    } dp_op_t;

    typedef enum logic [4:0] {
        FL_RET, FL_REPLAY, FL_LAST_CHECK, FL_HDR_DECIDE, FL_CONSUME,
        FL_FIELD_DONE, FL_VALUE_START, FL_VALUE_FMT, FL_BEGIN_SKIP, FL_SET_OPEN,
        FL_INT_EMIT, FL_ADVANCE, FL_CLOSE_TOP, FL_FINISH, FL_CLEAR, FL_FLUSH,
        FL_IDLE
    } follow_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        follow_t follow;
        logic    stall;
        logic    replay;
    } dp_stat_t;

endpackage

FILE: hdl/bej_ctrl.sv
// sequencing state machine for the bej decoder
module bej_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output bej_pkg::dp_cmd_t  cmd,
    input  bej_pkg::dp_stat_t stat
);
    import bej_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_HDR_DECIDE, S_REPLAY, S_CONSUME, S_FIELD_DONE,
        S_VALUE_START, S_VALUE_FMT, S_BEGIN_SKIP, S_SET_OPEN, S_INT_EMIT,
        S_ADVANCE, S_CLOSE_TOP, S_FINISH, S_LAST_CHECK, S_CLEAR, S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE) && !stat.stall;

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:        cmd.op = (in_valid && in_ready) ? OP_LATCH : OP_NONE;
            S_DISPATCH:    cmd.op = OP_DISPATCH;
            S_HDR_DECIDE:  cmd.op = OP_HDR_DECIDE;
            S_REPLAY:      cmd.op = OP_REPLAY;
            S_CONSUME:     cmd.op = OP_CONSUME;
            S_FIELD_DONE:  cmd.op = OP_FIELD_DONE;
            S_VALUE_START: cmd.op = OP_VALUE_START;
            S_VALUE_FMT:   cmd.op = OP_VALUE_FMT;
            S_BEGIN_SKIP:  cmd.op = OP_BEGIN_SKIP;
            S_SET_OPEN:    cmd.op = OP_SET_OPEN;
            S_INT_EMIT:    cmd.op = OP_INT_EMIT;
            S_ADVANCE:     cmd.op = OP_ADVANCE;
            S_CLOSE_TOP:   cmd.op = OP_CLOSE_TOP;
            S_FINISH:      cmd.op = OP_FINISH;
            S_LAST_CHECK:  cmd.op = OP_LAST_CHECK;
            S_CLEAR:       cmd.op = OP_CLEAR;
            S_FLUSH:       cmd.op = OP_FLUSH;
            default:       cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (state_reg == S_IDLE)
        begin
            if (in_valid && in_ready)
                state_next = S_DISPATCH;
        end
        else if (!stat.stall)
        begin
            unique case (stat.follow)
                FL_RET:         state_next = stat.replay ? S_REPLAY : S_LAST_CHECK;
                FL_REPLAY:      state_next = S_REPLAY;
                FL_LAST_CHECK:  state_next = S_LAST_CHECK;
                FL_HDR_DECIDE:  state_next = S_HDR_DECIDE;
                FL_CONSUME:     state_next = S_CONSUME;
                FL_FIELD_DONE:  state_next = S_FIELD_DONE;
                FL_VALUE_START: state_next = S_VALUE_START;
                FL_VALUE_FMT:   state_next = S_VALUE_FMT;
                FL_BEGIN_SKIP:  state_next = S_BEGIN_SKIP;
                FL_SET_OPEN:    state_next = S_SET_OPEN;
                FL_INT_EMIT:    state_next = S_INT_EMIT;
                FL_ADVANCE:     state_next = S_ADVANCE;
                FL_CLOSE_TOP:   state_next = S_CLOSE_TOP;
                FL_FINISH:      state_next = S_FINISH;
                FL_CLEAR:       state_next = S_CLEAR;
                FL_FLUSH:       state_next = S_FLUSH;
                FL_IDLE:        state_next = S_IDLE;
                default:        state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/bej_dp.sv
// datapath: stream state, set stack, event hold and output registers
module bej_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bej_pkg::dp_cmd_t            cmd,
    output bej_pkg::dp_stat_t           stat,
    input  logic                        cfg_wen,
    input  logic                        cfg_index,
    input  logic [5:0]                  cfg_data,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  event_kind,
    output logic signed [63:0]          event_value,
    output logic                        has_byte,
    output logic [bej_pkg::LEVEL_W-1:0] nesting_level,
    output logic [2:0]                  error_code,
    output logic                        last_of_run
);
    import bej_pkg::*;

    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    phase_t                 phase_reg, phase_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [63:0]            accum_reg, accum_next;
    logic [63:0]            left_reg, left_next;
    logic [31:0]            win_reg, win_next;
    logic [3:0]             nn_left_reg, nn_left_next;
    logic [2:0]             nn_idx_reg, nn_idx_next;
    logic [32:0]            seq_reg, seq_next;
    logic [OFFSET_BITS-1:0] pend_reg, pend_next;
    logic [3:0]             int_len_reg, int_len_next;
    logic [3:0]             int_idx_reg, int_idx_next;
    logic [3:0]             fmt_reg, fmt_next;
    logic [2:0]             fin_reg, fin_next;
    logic                   rmode_reg, rmode_next;
    logic [2:0]             ridx_reg, ridx_next;
    logic [2:0]             rn_reg, rn_next;
    logic                   strict_reg;
    logic [5:0]             dlim_reg;

    logic [63:0]            stk_rem [MAX_NESTING];
    logic [OFFSET_BITS-1:0] stk_end [MAX_NESTING];

    logic                   hold_v_reg, hold_v_next;
    logic [2:0]             hold_kind_reg, hold_kind_next;
    logic [63:0]            hold_val_reg, hold_val_next;
    logic                   hold_has_reg, hold_has_next;
    logic [LEVEL_W-1:0]     hold_lvl_reg, hold_lvl_next;
    logic [2:0]             hold_err_reg, hold_err_next;

    logic                   out_v_reg, out_v_next;
    logic [2:0]             out_kind_reg, out_kind_next;
    logic [63:0]            out_val_reg, out_val_next;
    logic                   out_has_reg, out_has_next;
    logic [LEVEL_W-1:0]     out_lvl_reg, out_lvl_next;
    logic [2:0]             out_err_reg, out_err_next;
    logic                   out_last_reg, out_last_next;

    logic                   stall;
    follow_t                follow;
    logic                   em;
    logic [2:0]             em_kind;
    logic [63:0]            em_val;
    logic                   em_has;
    logic [LEVEL_W-1:0]     em_lvl;
    logic [2:0]             em_err;
    logic                   flush;
    logic                   rem_we, end_we;
    logic [NEST_W-1:0]      rem_idx;
    logic [63:0]            rem_d;

    assign stall = hold_v_reg && out_v_reg && !out_ready;

    assign stat.follow = follow;
    assign stat.stall  = stall;
    assign stat.replay = rmode_reg;

    always_comb
    begin
        logic [7:0]             b;
        logic [31:0]            be;
        logic                   is_hdr;
        logic [NEST_W-1:0]      top;
        logic [63:0]            r;
        logic [LEVEL_W-1:0]     nl;
        logic [OFFSET_BITS-1:0] e;
        logic [64:0]            sum;
        logic [LEVEL_W-1:0]     lim;
        logic [5:0]             sh;
        logic signed [63:0]     sv;

        byte_next    = byte_reg;
        last_next    = last_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        offset_next  = offset_reg;
        accum_next   = accum_reg;
        left_next    = left_reg;
        win_next     = win_reg;
        nn_left_next = nn_left_reg;
        nn_idx_next  = nn_idx_reg;
        seq_next     = seq_reg;
        pend_next    = pend_reg;
        int_len_next = int_len_reg;
        int_idx_next = int_idx_reg;
        fmt_next     = fmt_reg;
        fin_next     = fin_reg;
        rmode_next   = rmode_reg;
        ridx_next    = ridx_reg;
        rn_next      = rn_reg;
        follow       = FL_RET;
        em           = 1'b0;
        em_kind      = EV_FINISHED;
        em_val       = '0;
        em_has       = 1'b0;
        em_lvl       = level_reg;
        em_err       = ST_OK;
        flush        = 1'b0;
        rem_we       = 1'b0;
        end_we       = 1'b0;
        rem_idx      = level_reg[NEST_W-1:0];
        rem_d        = accum_reg;

        b      = rmode_reg ? win_reg[{ridx_reg[1:0], 3'b000} +: 8] : byte_reg;
        be     = {win_reg[7:0], win_reg[15:8], win_reg[23:16], win_reg[31:24]};
        is_hdr = (win_reg == MAGIC_A) || (win_reg == MAGIC_B) || (be == MAGIC_A) ||
                 (be == MAGIC_B) || (win_reg[7:0] > NO_HDR_MAX);
        top    = NEST_W'(level_reg - 1'b1);
        r      = stk_rem[top] - 64'd1;
        nl     = level_reg - 1'b1;
        e      = stk_end[top];
        sum    = {1'b0, accum_reg} + {{(65-OFFSET_BITS){1'b0}}, offset_reg};
        lim    = (dlim_reg > NEST_CAP) ? NEST_CAP : dlim_reg;
        sh     = 6'd0 - {int_len_reg[2:0], 3'b000};
        sv     = $signed(accum_reg << sh);

        if (!stall)
        begin
            unique case (cmd.op)
                OP_NONE: ;
                OP_LATCH:
                begin
                    byte_next = data_byte;
                    last_next = last_byte;
                end
                OP_DISPATCH:
                begin
                    if (phase_reg == PH_HDR)
                    begin
                        win_next    = win_reg | (32'(byte_reg) << {offset_reg[1:0], 3'b000});
                        offset_next = offset_reg + 1'b1;
                        follow      = FL_HDR_DECIDE;
                    end
                    else if (phase_reg != PH_DONE)
                        follow = FL_CONSUME;
                end
                OP_HDR_DECIDE:
                begin
                    if (offset_reg[2] && is_hdr)
                    begin
                        offset_next = OFFSET_BITS'(HDR_PROBE);
                        left_next   = HDR_REST;
                        phase_next  = PH_HSKIP;
                    end
                    else if (offset_reg[2] || last_reg)
                    begin
                        // no header: run the buffered bytes through the tuple parser
                        offset_next = '0;
                        phase_next  = PH_SEQ_N;
                        ridx_next   = '0;
                        rn_next     = offset_reg[2:0];
                        rmode_next  = 1'b1;
                        follow      = FL_REPLAY;
                    end
                end
                OP_REPLAY:
                begin
                    if (ridx_reg < rn_reg && phase_reg != PH_DONE)
                        follow = FL_CONSUME;
                    else
                    begin
                        rmode_next = 1'b0;
                        follow     = FL_LAST_CHECK;
                    end
                end
                OP_CONSUME:
                begin
                    if (rmode_reg)
                        ridx_next = ridx_reg + 1'b1;
                    if (offset_reg != OFF_MAX)
                        offset_next = offset_reg + 1'b1;
                    case (phase_reg)
                        PH_HSKIP:
                        begin
                            left_next = left_reg - 64'd1;
                            if (left_reg == 64'd1)
                                phase_next = PH_SEQ_N;
                        end
                        PH_SEQ_N, PH_LEN_N, PH_CNT_N:
                        begin
                            accum_next = '0;
                            phase_next = (phase_reg == PH_SEQ_N) ? PH_SEQ_B :
                                         (phase_reg == PH_LEN_N) ? PH_LEN_B : PH_CNT_B;
                            if (b == 8'd0)
                                follow = FL_FIELD_DONE;
                            else if (b > NN_MAX)
                            begin
                                phase_next = phase_reg;
                                fin_next   = ST_PARSE;
                                follow     = FL_FINISH;
                            end
                            else
                            begin
                                nn_left_next = b[3:0];
                                nn_idx_next  = '0;
                            end
                        end
                        PH_SEQ_B, PH_LEN_B, PH_CNT_B:
                        begin
                            accum_next   = accum_reg | (64'(b) << {nn_idx_reg, 3'b000});
                            nn_idx_next  = nn_idx_reg + 1'b1;
                            nn_left_next = nn_left_reg - 1'b1;
                            if (nn_left_reg == 4'd1)
                                follow = FL_FIELD_DONE;
                        end
                        PH_FMT:
                        begin
                            fmt_next   = b[7:4];
                            phase_next = PH_LEN_N;
                        end
                        PH_STR:
                        begin
                            left_next = left_reg - 64'd1;
                            em        = 1'b1;
                            em_val    = 64'(b);
                            if (left_reg != 64'd1)
                                em_kind = EV_STR_BYTE;
                            else
                            begin
                                em_kind = EV_STR_END;
                                em_has  = (b != 8'd0);
                                follow  = FL_ADVANCE;
                            end
                        end
                        PH_INT:
                        begin
                            if (!int_idx_reg[3])
                            begin
                                accum_next   = accum_reg | (64'(b) << {int_idx_reg[2:0], 3'b000});
                                int_idx_next = int_idx_reg + 1'b1;
                            end
                            left_next = left_reg - 64'd1;
                            if (left_reg == 64'd1)
                                follow = FL_INT_EMIT;
                        end
                        PH_SKIP, PH_SLACK:
                        begin
                            left_next = left_reg - 64'd1;
                            if (left_reg == 64'd1)
                                follow = FL_ADVANCE;
                        end
                        default: ;
                    endcase
                end
                OP_FIELD_DONE:
                begin
                    case (phase_reg)
                        PH_SEQ_B:
                        begin
                            seq_next   = accum_reg[32:0];
                            phase_next = PH_FMT;
                        end
                        PH_LEN_B: follow = FL_VALUE_START;
                        PH_CNT_B: follow = FL_SET_OPEN;
                        default: ;
                    endcase
                end
                OP_VALUE_START:
                begin
                    if (seq_reg[0])
                    begin
                        // annotation tuple: skipped whole
                        em      = 1'b1;
                        em_kind = EV_SKIPPED;
                        em_val  = accum_reg;
                        follow  = FL_BEGIN_SKIP;
                    end
                    else
                    begin
                        em      = (level_reg != '0);
                        em_kind = EV_KEY;
                        em_val  = {32'd0, seq_reg[32:1]};
                        follow  = FL_VALUE_FMT;
                    end
                end
                OP_VALUE_FMT:
                begin
                    case (fmt_reg)
                        FMT_SET:
                        begin
                            pend_next  = (sum > 65'(OFF_MAX)) ? OFF_MAX : sum[OFFSET_BITS-1:0];
                            phase_next = PH_CNT_N;
                        end
                        FMT_STRING:
                        begin
                            if (accum_reg == '0)
                            begin
                                em      = 1'b1;
                                em_kind = EV_STR_END;
                                follow  = FL_ADVANCE;
                            end
                            else
                            begin
                                left_next  = accum_reg;
                                phase_next = PH_STR;
                            end
                        end
                        FMT_INTEGER:
                        begin
                            if (strict_reg && accum_reg > 64'd8)
                            begin
                                fin_next = ST_UNSUP;
                                follow   = FL_FINISH;
                            end
                            else if (accum_reg == '0)
                            begin
                                em      = 1'b1;
                                em_kind = EV_INT;
                                follow  = FL_ADVANCE;
                            end
                            else
                            begin
                                int_len_next = (accum_reg >= 64'd8) ? 4'd8 : accum_reg[3:0];
                                int_idx_next = '0;
                                left_next    = accum_reg;
                                accum_next   = '0;
                                phase_next   = PH_INT;
                            end
                        end
                        default:
                        begin
                            if (strict_reg)
                            begin
                                fin_next = ST_UNSUP;
                                follow   = FL_FINISH;
                            end
                            else
                            begin
                                em      = 1'b1;
                                em_kind = EV_SKIPPED;
                                em_val  = accum_reg;
                                follow  = FL_BEGIN_SKIP;
                            end
                        end
                    endcase
                end
                OP_BEGIN_SKIP:
                begin
                    if (accum_reg == '0)
                        follow = FL_ADVANCE;
                    else
                    begin
                        left_next  = accum_reg;
                        phase_next = PH_SKIP;
                    end
                end
                OP_SET_OPEN:
                begin
                    em      = 1'b1;
                    em_kind = EV_SET_BEGIN;
                    em_val  = accum_reg;
                    if ({1'b0, level_reg} + 7'd1 > {1'b0, lim} || level_reg >= NEST_FULL)
                    begin
                        fin_next = ST_DEPTH;
                        follow   = FL_FINISH;
                    end
                    else
                    begin
                        rem_we     = 1'b1;
                        end_we     = 1'b1;
                        level_next = level_reg + 1'b1;
                        if (accum_reg == '0)
                            follow = FL_CLOSE_TOP;
                        else
                            phase_next = PH_SEQ_N;
                    end
                end
                OP_INT_EMIT:
                begin
                    em      = 1'b1;
                    em_kind = EV_INT;
                    em_val  = int_len_reg[3] ? accum_reg : 64'(sv >>> sh);
                    follow  = FL_ADVANCE;
                end
                OP_ADVANCE:
                begin
                    if (level_reg == '0)
                    begin
                        fin_next = ST_OK;
                        follow   = FL_FINISH;
                    end
                    else
                    begin
                        rem_we  = 1'b1;
                        rem_idx = top;
                        rem_d   = r;
                        if (r != '0)
                            phase_next = PH_SEQ_N;
                        else
                            follow = FL_CLOSE_TOP;
                    end
                end
                OP_CLOSE_TOP:
                begin
                    level_next = nl;
                    em         = 1'b1;
                    em_kind    = EV_SET_END;
                    em_lvl     = nl;
                    if (offset_reg > e)
                    begin
                        fin_next = ST_PARSE;
                        follow   = FL_FINISH;
                    end
                    else if (offset_reg < e)
                    begin
                        left_next  = 64'(e - offset_reg);
                        phase_next = PH_SLACK;
                    end
                    else
                        follow = FL_ADVANCE;
                end
                OP_FINISH:
                begin
                    em         = 1'b1;
                    em_kind    = EV_FINISHED;
                    em_val     = 64'(offset_reg);
                    em_err     = fin_reg;
                    phase_next = PH_DONE;
                end
                OP_LAST_CHECK:
                begin
                    if (!last_reg)
                        follow = FL_FLUSH;
                    else if (phase_reg == PH_SLACK && !strict_reg)
                        follow = FL_ADVANCE;
                    else if (phase_reg != PH_DONE)
                    begin
                        fin_next = ST_TRUNC;
                        follow   = FL_FINISH;
                    end
                    else
                        follow = FL_CLEAR;
                end
                OP_CLEAR:
                begin
                    level_next   = '0;
                    offset_next  = '0;
                    phase_next   = PH_HDR;
                    accum_next   = '0;
                    left_next    = '0;
                    win_next     = '0;
                    nn_left_next = '0;
                    nn_idx_next  = '0;
                    seq_next     = '0;
                    pend_next    = '0;
                    int_len_next = '0;
                    int_idx_next = '0;
                    fmt_next     = '0;
                    follow       = FL_FLUSH;
                end
                OP_FLUSH:
                begin
                    flush  = 1'b1;
                    follow = FL_IDLE;
                end
                default: ;
            endcase
        end
    end

    // event hold stage: the newest event waits here until we know if it ends the run
    always_comb
    begin
        hold_v_next    = hold_v_reg;
        hold_kind_next = hold_kind_reg;
        hold_val_next  = hold_val_reg;
        hold_has_next  = hold_has_reg;
        hold_lvl_next  = hold_lvl_reg;
        hold_err_next  = hold_err_reg;
        out_v_next     = out_v_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_val_next   = out_val_reg;
        out_has_next   = out_has_reg;
        out_lvl_next   = out_lvl_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        if (!stall && hold_v_reg && (em || flush))
        begin
            out_v_next    = 1'b1;
            out_kind_next = hold_kind_reg;
            out_val_next  = hold_val_reg;
            out_has_next  = hold_has_reg;
            out_lvl_next  = hold_lvl_reg;
            out_err_next  = hold_err_reg;
            out_last_next = flush;
        end
        if (!stall && em)
        begin
            hold_v_next    = 1'b1;
            hold_kind_next = em_kind;
            hold_val_next  = em_val;
            hold_has_next  = em_has;
            hold_lvl_next  = em_lvl;
            hold_err_next  = em_err;
        end
        else if (!stall && flush)
            hold_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg    <= '0;
            last_reg    <= 1'b0;
            phase_reg   <= PH_HDR;
            level_reg   <= '0;
            offset_reg  <= '0;
            accum_reg   <= '0;
            left_reg    <= '0;
            win_reg     <= '0;
            nn_left_reg <= '0;
            nn_idx_reg  <= '0;
            seq_reg     <= '0;
            pend_reg    <= '0;
            int_len_reg <= '0;
            int_idx_reg <= '0;
            fmt_reg     <= '0;
            fin_reg     <= ST_OK;
            rmode_reg   <= 1'b0;
            ridx_reg    <= '0;
            rn_reg      <= '0;
            strict_reg  <= 1'b1;
            dlim_reg    <= 6'd32;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            byte_reg    <= byte_next;
            last_reg    <= last_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            offset_reg  <= offset_next;
            accum_reg   <= accum_next;
            left_reg    <= left_next;
            win_reg     <= win_next;
            nn_left_reg <= nn_left_next;
            nn_idx_reg  <= nn_idx_next;
            seq_reg     <= seq_next;
            pend_reg    <= pend_next;
            int_len_reg <= int_len_next;
            int_idx_reg <= int_idx_next;
            fmt_reg     <= fmt_next;
            fin_reg     <= fin_next;
            rmode_reg   <= rmode_next;
            ridx_reg    <= ridx_next;
            rn_reg      <= rn_next;
            hold_v_reg  <= hold_v_next;
            out_v_reg   <= out_v_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_STRICT: strict_reg <= cfg_data[0];
                    CFG_DEPTH:  dlim_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_kind_reg <= hold_kind_next;
        hold_val_reg  <= hold_val_next;
        hold_has_reg  <= hold_has_next;
        hold_lvl_reg  <= hold_lvl_next;
        hold_err_reg  <= hold_err_next;
        out_kind_reg  <= out_kind_next;
        out_val_reg   <= out_val_next;
        out_has_reg   <= out_has_next;
        out_lvl_reg   <= out_lvl_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
        if (rem_we)
            stk_rem[rem_idx] <= rem_d;
        if (end_we)
            stk_end[level_reg[NEST_W-1:0]] <= pend_reg;
    end

    assign out_valid     = out_v_reg;
    assign event_kind    = out_kind_reg;
    assign event_value   = $signed(out_val_reg);
    assign has_byte      = out_has_reg;
    assign nesting_level = out_lvl_reg;
    assign error_code    = out_err_reg;
    assign last_of_run   = out_last_reg;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= NEST_FULL)
        else $error("set level beyond stack size");

    a_err_only_finished: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg && hold_err_reg != ST_OK |-> hold_kind_reg == EV_FINISHED)
        else $error("error code on a non-finished event");

    a_hdr_offset: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR |-> offset_reg <= OFFSET_BITS'(HDR_PROBE))
        else $error("header probe offset out of range");

    a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
        rmode_reg |-> ridx_reg <= rn_reg && rn_reg <= HDR_PROBE)
        else $error("replay index past buffered bytes");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> hold_v_reg)
        else $error("held event lost during stall");
`endif

endmodule

FILE: hdl/bej_tuple_stream_decoder.sv
// top level of the bej tuple stream decoder
// throughput: one byte at a time; ready returns only after a byte's transaction has run its steps
// (dispatch, consume or header decide, end check, flush); field done, value start, value format,
// set open and integer emit add a step each, a set close cascade adds steps per level, replayed
// probe bytes add their own steps, and stream end adds a finish and a clear step
// output: an event leaves the hold stage with the next event or the byte's flush;
// full hold and output with out_ready low stall it
// reset clears all stream state, strict_mode to 1, depth_limit 32
module bej_tuple_stream_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  event_kind,
    output logic signed [63:0]          event_value,
    output logic                        has_byte,
    output logic [bej_pkg::LEVEL_W-1:0] nesting_level,
    output logic [2:0]                  error_code,
    output logic                        last_of_run,
    input  logic                        cfg_wen,
    input  logic                        cfg_index,
    input  logic [5:0]                  cfg_data
);
    import bej_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bej_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bej_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .event_value   (event_value),
        .has_byte      (has_byte),
        .nesting_level (nesting_level),
        .error_code    (error_code),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: tb/bej_event_checker.sv
// event predictor and scoreboard for the bej tuple stream decoder
module bej_event_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [2:0]                  event_kind,
    input  logic signed [63:0]          event_value,
    input  logic                        has_byte,
    input  logic [bej_pkg::LEVEL_W-1:0] nesting_level,
    input  logic [2:0]                  error_code,
    input  logic                        last_of_run,
    input  logic                        cfg_wen,
    input  logic                        cfg_index,
    input  logic [5:0]                  cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import bej_pkg::*;

    localparam logic [63:0] OFF_LIMIT = 64'(OFF_MAX);
    localparam int EVENT_CAP = 40;

    typedef struct {
        logic [2:0]         kind;
        logic [63:0]        value;
        logic               has;
        logic [LEVEL_W-1:0] level;
        logic [2:0]         err;
        logic               last;
    } bej_event_t;

    bej_event_t expected_events[$];
    bej_event_t step_events[$];

    // decoder state mirror
    logic [63:0] set_remaining [MAX_NESTING];
    logic [63:0] set_end_off [MAX_NESTING];
    int          open_sets;
    logic [63:0] offset;
    phase_t      phase;
    logic [63:0] accum;
    logic [63:0] remaining;
    logic [31:0] window;
    int          nn_count;
    int          nn_shift;
    logic [63:0] seq_num;
    logic [63:0] pending_end;
    logic [63:0] int_bytes;
    logic [7:0]  fmt_byte;
    logic        strict_on;
    logic [5:0]  depth_max;

    function automatic void clear_stream();
        for (int i = 0; i < MAX_NESTING; i++)
        begin
            set_remaining[i] = '0;
            set_end_off[i] = '0;
        end
        open_sets = 0;
        offset = '0;
        phase = PH_HDR;
        accum = '0;
        remaining = '0;
        window = '0;
        nn_count = 0;
        nn_shift = 0;
        seq_num = '0;
        pending_end = '0;
        int_bytes = '0;
        fmt_byte = '0;
    endfunction

    function automatic void add_event(logic [2:0] kind, logic [63:0] value, logic has,
                                      logic [2:0] err);
        bej_event_t ev;
        if (step_events.size() >= EVENT_CAP)
            return;
        ev.kind = kind;
        ev.value = value;
        ev.has = has;
        ev.level = LEVEL_W'(open_sets);
        ev.err = err;
        ev.last = 1'b0;
        step_events.push_back(ev);
    endfunction

    function automatic void end_stream(logic [2:0] code);
        add_event(EV_FINISHED, offset, 1'b0, code);
        phase = PH_DONE;
    endfunction

    function automatic bit close_set();
        logic [63:0] e;
        open_sets--;
        e = set_end_off[open_sets];
        add_event(EV_SET_END, '0, 1'b0, ST_OK);
        if (offset > e)
        begin
            end_stream(ST_PARSE);
            return 1'b0;
        end
        if (offset < e)
        begin
            remaining = e - offset;
            phase = PH_SLACK;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // a tuple is complete: count it against the enclosing sets
    function automatic void tuple_done();
        int i;
        forever
        begin
            if (open_sets == 0)
            begin
                end_stream(ST_OK);
                return;
            end
            i = open_sets - 1;
            set_remaining[i]--;
            if (set_remaining[i] != 0)
            begin
                phase = PH_SEQ_N;
                return;
            end
            if (!close_set())
                return;
        end
    endfunction

    function automatic void skip_value(logic [63:0] len);
        if (len == 0)
        begin
            tuple_done();
            return;
        end
        remaining = len;
        phase = PH_SKIP;
    endfunction

    function automatic void start_value(logic [63:0] len);
        if (seq_num[0])
        begin
            add_event(EV_SKIPPED, len, 1'b0, ST_OK);
            skip_value(len);
            return;
        end
        if (open_sets > 0)
            add_event(EV_KEY, {32'd0, seq_num[32:1]}, 1'b0, ST_OK);
        case (fmt_byte[7:4])
            FMT_SET:
            begin
                pending_end = (len > OFF_LIMIT - offset) ? OFF_LIMIT : offset + len;
                phase = PH_CNT_N;
            end
            FMT_STRING:
            begin
                if (len == 0)
                begin
                    add_event(EV_STR_END, '0, 1'b0, ST_OK);
                    tuple_done();
                end
                else
                begin
                    remaining = len;
                    phase = PH_STR;
                end
            end
            FMT_INTEGER:
            begin
                if (strict_on && len > 8)
                    end_stream(ST_UNSUP);
                else if (len == 0)
                begin
                    add_event(EV_INT, '0, 1'b0, ST_OK);
                    tuple_done();
                end
                else
                begin
                    int_bytes = len;
                    remaining = len;
                    accum = '0;
                    phase = PH_INT;
                end
            end
            default:
            begin
                if (strict_on)
                    end_stream(ST_UNSUP);
                else
                begin
                    add_event(EV_SKIPPED, len, 1'b0, ST_OK);
                    skip_value(len);
                end
            end
        endcase
    endfunction

    function automatic void open_set(logic [63:0] count);
        int lim;
        lim = (depth_max > NEST_CAP) ? int'(NEST_CAP) : int'(depth_max);
        add_event(EV_SET_BEGIN, count, 1'b0, ST_OK);
        if (open_sets + 1 > lim || open_sets >= MAX_NESTING)
        begin
            end_stream(ST_DEPTH);
            return;
        end
        set_remaining[open_sets] = count;
        set_end_off[open_sets] = pending_end;
        open_sets++;
        if (count == 0)
        begin
            if (close_set())
                tuple_done();
        end
        else
            phase = PH_SEQ_N;
    endfunction

    function automatic void field_complete(phase_t ph, logic [63:0] v);
        if (ph == PH_SEQ_B)
        begin
            seq_num = v;
            phase = PH_FMT;
        end
        else if (ph == PH_LEN_B)
            start_value(v);
        else
            open_set(v);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        phase_t ph;
        logic [63:0] idx;
        logic [63:0] v;
        logic [63:0] mask;
        int bits;
        ph = phase;
        if (offset < OFF_LIMIT)
            offset++;
        case (ph)
            PH_HSKIP:
            begin
                remaining--;
                if (remaining == 0)
                    phase = PH_SEQ_N;
            end
            PH_SEQ_N, PH_LEN_N, PH_CNT_N:
            begin
                if (b == 0)
                    field_complete(phase_t'(ph + 1), '0);
                else if (b > NN_MAX)
                    end_stream(ST_PARSE);
                else
                begin
                    nn_count = b;
                    nn_shift = 0;
                    accum = '0;
                    phase = phase_t'(ph + 1);
                end
            end
            PH_SEQ_B, PH_LEN_B, PH_CNT_B:
            begin
                accum |= 64'(b) << (nn_shift & 63);
                nn_shift += 8;
                nn_count--;
                if (nn_count == 0)
                    field_complete(ph, accum);
            end
            PH_FMT:
            begin
                fmt_byte = b;
                phase = PH_LEN_N;
            end
            PH_STR:
            begin
                remaining--;
                if (remaining != 0)
                    add_event(EV_STR_BYTE, 64'(b), 1'b0, ST_OK);
                else
                begin
                    add_event(EV_STR_END, 64'(b), b != 0, ST_OK);
                    tuple_done();
                end
            end
            PH_INT:
            begin
                idx = int_bytes - remaining;
                if (idx < 8)
                    accum |= 64'(b) << (8 * idx[2:0]);
                remaining--;
                if (remaining == 0)
                begin
                    v = accum;
                    if (int_bytes < 8)
                    begin
                        bits = 8 * int'(int_bytes);
                        mask = (64'd1 << bits) - 1;
                        if (v[bits-1])
                            v |= ~mask;
                    end
                    add_event(EV_INT, v, 1'b0, ST_OK);
                    tuple_done();
                end
            end
            PH_SKIP, PH_SLACK:
            begin
                remaining--;
                if (remaining == 0)
                    tuple_done();
            end
            default: ;
        endcase
    endfunction

    // buffered probe bytes turned out not to be a header
    function automatic void replay_window(int n);
        offset = '0;
        phase = PH_SEQ_N;
        for (int i = 0; i < n && i < 4 && phase != PH_DONE; i++)
            take_byte(window[8*i +: 8]);
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [31:0] le;
        logic [31:0] be;
        step_events.delete();
        if (phase == PH_HDR)
        begin
            window |= 32'(b) << (8 * offset[1:0]);
            offset++;
            if (offset >= 4)
            begin
                le = window;
                be = {le[7:0], le[15:8], le[23:16], le[31:24]};
                if (le == MAGIC_A || le == MAGIC_B || be == MAGIC_A || be == MAGIC_B ||
                    le[7:0] > NO_HDR_MAX)
                begin
                    offset = 64'd4;
                    remaining = HDR_REST;
                    phase = PH_HSKIP;
                end
                else
                    replay_window(4);
            end
            else if (last)
                replay_window(int'(offset));
        end
        else if (phase != PH_DONE)
            take_byte(b);
        if (last)
        begin
            while (phase == PH_SLACK && !strict_on)
                tuple_done();
            if (phase != PH_DONE)
                end_stream(ST_TRUNC);
            clear_stream();
        end
        if (step_events.size() > 0)
            step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bej_event_t ev;
        if (!rst_n)
        begin
            clear_stream();
            strict_on = 1'b1;
            depth_max = 6'd32;
            expected_events.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == CFG_STRICT)
                    strict_on = cfg_data[0];
                else
                    depth_max = cfg_data;
            end
            if (in_valid && in_ready)
                predict_byte(data_byte, last_byte);
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event kind %0d value %0d", event_kind, event_value);
                    errors++;
                end
                else
                begin
                    ev = expected_events.pop_front();
                    checked++;
                    if (event_kind !== ev.kind)
                    begin
                        $error("event_kind expected %0d actual %0d", ev.kind, event_kind);
                        errors++;
                    end
                    if (event_value !== ev.value)
                    begin
                        $error("event_value expected %0h actual %0h", ev.value, event_value);
                        errors++;
                    end
                    if (has_byte !== ev.has)
                    begin
                        $error("has_byte expected %0d actual %0d", ev.has, has_byte);
                        errors++;
                    end
                    if (nesting_level !== ev.level)
                    begin
                        $error("nesting_level expected %0d actual %0d", ev.level,
                               nesting_level);
                        errors++;
                    end
                    if (error_code !== ev.err)
                    begin
                        $error("error_code expected %0d actual %0d", ev.err, error_code);
                        errors++;
                    end
                    if (last_of_run !== ev.last)
                    begin
                        $error("last_of_run expected %0d actual %0d", ev.last, last_of_run);
                        errors++;
                    end
                end
            end
        end
        pending = expected_events.size();
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for the bej tuple stream decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bej_pkg::*;

    typedef logic [7:0] byte_list_t[$];

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         event_kind;
    logic signed [63:0] event_value;
    logic               has_byte;
    logic [LEVEL_W-1:0] nesting_level;
    logic [2:0]         error_code;
    logic               last_of_run;
    logic               cfg_wen;
    logic               cfg_index;
    logic [5:0]         cfg_data;

    int  errors;
    int  pending;
    int  checked;
    int  cycles;
    int  bytes_sent;
    int  streams_sent;
    bit  calm;
    bit  hold_req;
    int  hold_left;

    bej_tuple_stream_decoder dut (.*);

    bej_event_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_ready = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = CFG_STRICT;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        cycles = 0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    function automatic byte_list_t nnint(logic [63:0] v);
        byte_list_t q;
        int n;
        n = 0;
        for (int i = 0; i < 8; i++)
            if (v[8*i +: 8] != 0)
                n = i + 1;
        if (n < 8 && $urandom_range(0, 5) == 0)
            n++;
        q.push_back(8'(n));
        for (int i = 0; i < n; i++)
            q.push_back(v[8*i +: 8]);
        return q;
    endfunction

    function automatic byte_list_t make_tuple(int depth);
        byte_list_t body;
        byte_list_t q;
        logic [63:0] seq;
        logic [3:0] nib;
        int sel;
        int n;
        seq = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
        seq[0] = ($urandom_range(0, 7) == 0);
        sel = $urandom_range(0, 9);
        if (depth < 3 && sel < 3)
        begin
            nib = FMT_SET;
            n = $urandom_range(0, 3);
            body = nnint(64'(n));
            for (int i = 0; i < n; i++)
                body = {body, make_tuple(depth + 1)};
            // slack after the last child
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    body.push_back(8'($urandom));
        end
        else if (sel < 6)
        begin
            nib = FMT_STRING;
            n = $urandom_range(0, 6);
            repeat (n)
                body.push_back(8'($urandom));
            if (n > 0 && $urandom_range(0, 1) == 0)
                body[n-1] = 8'h00;
        end
        else if (sel < 9)
        begin
            nib = FMT_INTEGER;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
            repeat (n)
                body.push_back(8'($urandom));
        end
        else
        begin
            do
                nib = 4'($urandom);
            while (nib == FMT_SET || nib == FMT_STRING || nib == FMT_INTEGER);
            repeat ($urandom_range(0, 4))
                body.push_back(8'($urandom));
        end
        q = {nnint(seq), {nib, 4'($urandom)}, nnint(64'(body.size())), body};
        return q;
    endfunction

    // chain of single-child sets, for depth limits
    function automatic byte_list_t nested_sets(int levels);
        byte_list_t body;
        if (levels == 0)
            body = {8'h00, 8'h00};
        else
            body = {8'h01, 8'h01, nested_sets(levels - 1)};
        return {8'h00, {FMT_SET, 4'h0}, nnint(64'(body.size())), body};
    endfunction

    function automatic byte_list_t make_header();
        byte_list_t q;
        case ($urandom_range(0, 4))
            0: q = {MAGIC_A[7:0], MAGIC_A[15:8], MAGIC_A[23:16], MAGIC_A[31:24]};
            1: q = {MAGIC_B[7:0], MAGIC_B[15:8], MAGIC_B[23:16], MAGIC_B[31:24]};
            2: q = {MAGIC_A[31:24], MAGIC_A[23:16], MAGIC_A[15:8], MAGIC_A[7:0]};
            3: q = {MAGIC_B[31:24], MAGIC_B[23:16], MAGIC_B[15:8], MAGIC_B[7:0]};
            default: q = {8'($urandom_range(9, 255)), 8'($urandom), 8'($urandom),
                          8'($urandom)};
        endcase
        repeat (3)
            q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic byte_list_t make_stream();
        byte_list_t q;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            repeat ($urandom_range(1, 10))
                q.push_back(8'($urandom));
            return q;
        end
        if ($urandom_range(0, 1) == 0)
            q = make_header();
        q = {q, make_tuple(0)};
        if (sel == 1 && q.size() > 1)
            q = q[0:$urandom_range(0, q.size() - 2)];
        else if (sel == 2)
            repeat ($urandom_range(1, 3))
                q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic send_stream(byte_list_t q);
        foreach (q[i])
        begin
            if (!calm && $urandom_range(0, 99) < 11)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4))
                    @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= q[i];
            last_byte <= (i == q.size() - 1);
            @(negedge clk);
            while (!in_ready)
                @(negedge clk);
            @(posedge clk);
            bytes_sent++;
        end
        in_valid <= 1'b0;
        streams_sent++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic set_config(logic strict, logic [5:0] depth);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_index <= CFG_STRICT;
        cfg_data <= {5'd0, strict};
        @(posedge clk);
        cfg_index <= CFG_DEPTH;
        cfg_data <= depth;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        logic strict_set [6];
        logic [5:0] depth_set [6];
        int target;
        strict_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        depth_set = '{6'd32, 6'd32, 6'd0, 6'd1, 6'd3, 6'd32};
        bytes_sent = 0;
        streams_sent = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(1'b1, 6'd32);
        // short streams, empty string, oversized count, extreme integers, deep nesting
        send_stream({8'h00, {FMT_STRING, 4'h0}, 8'h00});
        send_stream({8'hFF});
        send_stream({8'h09});
        send_stream({MAGIC_A[7:0], MAGIC_A[15:8], MAGIC_A[23:16], MAGIC_A[31:24],
                     8'h00, 8'h00, 8'h00, 8'h00, {FMT_INTEGER, 4'h0}, 8'h01, 8'h08,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80});
        send_stream({8'h01, 8'hFF, {FMT_INTEGER, 4'h0}, 8'h01, 8'h02, 8'hFF, 8'h7F});
        send_stream(nested_sets(33));

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                set_config(strict_set[ph], depth_set[ph]);
            calm = (ph == 4);
            if (ph == 1)
                send_stream({8'h00, {FMT_INTEGER, 4'h0}, 8'h01, 8'h0A, 8'h81, 8'h01,
                             8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
            if (ph == 2)
            begin
                hold_req = 1'b1;
                send_stream(nested_sets(2));
            end
            target = bytes_sent + 20;
            while (bytes_sent < target)
                send_stream(make_stream());
        end

        wait_idle();
        $display("decoded %0d streams (%0d bytes) over 6 register settings", streams_sent,
                 bytes_sent);
        $display("%0d events compared, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: bej_tuple_stream_decoder.f
hdl/bej_pkg.sv
hdl/bej_ctrl.sv
hdl/bej_dp.sv
hdl/bej_tuple_stream_decoder.sv
tb/bej_event_checker.sv
tb/testbench.sv
